// File: rtl/icv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ICMP echo reply validator.
package icv_pkg;

    localparam int HEADER_BYTES      = 8;
    localparam int MAX_PAYLOAD_BYTES = 8;
    localparam int POS_W             = 5;
    localparam int TOTAL_W           = POS_W + 1;
    localparam int LEN_W             = 4;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] TYPE_REPLY_V4 = 8'd0;
    localparam logic [7:0] TYPE_REPLY_V6 = 8'd129;

    localparam logic [63:0] PATTERN_RESET = 64'h5B70_3470_696E_675D;

    typedef enum logic [1:0] {
        REG_IPV4_MODE       = 2'd0,
        REG_OWN_IDENT       = 2'd1,
        REG_PAYLOAD_PATTERN = 2'd2,
        REG_PAYLOAD_LENGTH  = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_TYPE     = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_CHECKSUM = 3'd4,
        ST_IDENT    = 3'd5,
        ST_SEQUENCE = 3'd6,
        ST_PAYLOAD  = 3'd7
    } t_status;

    typedef struct packed {
        logic             ipv4_mode;
        logic [15:0]      own_ident;
        logic [63:0]      payload_pattern;
        logic [LEN_W-1:0] payload_length;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [7:0] reply_code;
    } t_result;

endpackage

// File: rtl/icv_check.sv
`timescale 1ns / 1ps
// Per-byte message state, running checksum and final status decision.
module icv_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  icv_pkg::t_cfg      i_cfg,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic [15:0]        i_expected_seq,
    output logic               o_push,
    output icv_pkg::t_result   o_result
);

    logic [icv_pkg::POS_W-1:0] r_pos, n_pos;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_csum, n_csum;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_code, n_code;
    logic [15:0] r_ident, n_ident;
    logic [15:0] r_seq, n_seq;
    logic [15:0] r_exp_seq, n_exp_seq;
    logic        r_mismatch, n_mismatch;
    logic [7:0]  r_pending, n_pending;

    logic [icv_pkg::LEN_W-1:0]   w_plen;
    logic [icv_pkg::POS_W-1:0]   w_off;
    logic                        w_in_payload;
    logic [7:0]                  w_want;
    logic [7:0]                  w_counted;
    logic                        w_add;
    logic [15:0]                 w_word;
    logic [16:0]                 w_raw;
    logic [icv_pkg::TOTAL_W-1:0] w_total;
    logic [icv_pkg::TOTAL_W-1:0] w_exp_total;
    logic [7:0]                  w_want_type;
    icv_pkg::t_status            w_status;

    always_comb begin
        w_plen = (i_cfg.payload_length > icv_pkg::LEN_W'(icv_pkg::MAX_PAYLOAD_BYTES))
               ? icv_pkg::LEN_W'(icv_pkg::MAX_PAYLOAD_BYTES) : i_cfg.payload_length;
        w_off = r_pos - icv_pkg::POS_W'(icv_pkg::HEADER_BYTES);
        w_in_payload = (r_pos >= icv_pkg::POS_W'(icv_pkg::HEADER_BYTES))
                     && (w_off < icv_pkg::POS_W'(w_plen));
        w_want = i_cfg.payload_pattern[(3'd7 - w_off[2:0]) * 8 +: 8];
        w_counted = (r_pos == 5'd2 || r_pos == 5'd3) ? 8'd0 : i_data_byte;

        n_type     = r_type;
        n_code     = r_code;
        n_csum     = r_csum;
        n_ident    = r_ident;
        n_seq      = r_seq;
        n_exp_seq  = r_exp_seq;
        n_mismatch = r_mismatch;
        unique case (r_pos)
            5'd0: begin
                n_type    = i_data_byte;
                n_exp_seq = i_expected_seq;
            end
            5'd1: n_code = i_data_byte;
            5'd2: n_csum[15:8] = i_data_byte;
            5'd3: n_csum[7:0] = i_data_byte;
            5'd4: n_ident[15:8] = i_data_byte;
            5'd5: n_ident[7:0] = i_data_byte;
            5'd6: n_seq[15:8] = i_data_byte;
            5'd7: n_seq[7:0] = i_data_byte;
            default: begin
                if (w_in_payload && w_want != i_data_byte) begin
                    n_mismatch = 1'b1;
                end
            end
        endcase

        n_pending = r_pending;
        if (!r_pos[0]) begin
            n_pending = w_counted;
            w_add  = i_last_byte;
            w_word = {w_counted, 8'd0};
        end else begin
            w_add  = 1'b1;
            w_word = {r_pending, w_counted};
        end
        w_raw = {1'b0, r_sum} + {1'b0, w_word};
        n_sum = w_add ? (w_raw[15:0] + {15'd0, w_raw[16]}) : r_sum;

        n_pos = (r_pos < icv_pkg::POS_MAX) ? r_pos + 5'd1 : r_pos;

        w_total     = {1'b0, r_pos} + icv_pkg::TOTAL_W'(1);
        w_exp_total = icv_pkg::TOTAL_W'(icv_pkg::HEADER_BYTES) + icv_pkg::TOTAL_W'(w_plen);
        w_want_type = i_cfg.ipv4_mode ? icv_pkg::TYPE_REPLY_V4 : icv_pkg::TYPE_REPLY_V6;

        priority if (w_total < icv_pkg::TOTAL_W'(icv_pkg::HEADER_BYTES)) begin
            w_status = icv_pkg::ST_SHORT;
        end else if (n_type != w_want_type) begin
            w_status = icv_pkg::ST_TYPE;
        end else if (w_total != w_exp_total) begin
            w_status = icv_pkg::ST_LENGTH;
        end else if (i_cfg.ipv4_mode && (~n_sum != n_csum)) begin
            w_status = icv_pkg::ST_CHECKSUM;
        end else if (n_ident != i_cfg.own_ident) begin
            w_status = icv_pkg::ST_IDENT;
        end else if (n_seq != n_exp_seq) begin
            w_status = icv_pkg::ST_SEQUENCE;
        end else if (n_mismatch) begin
            w_status = icv_pkg::ST_PAYLOAD;
        end else begin
            w_status = icv_pkg::ST_OK;
        end

        o_push              = i_accept && i_last_byte;
        o_result.status     = w_status;
        o_result.reply_code = (w_status == icv_pkg::ST_OK) ? n_code : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_csum     <= '0;
            r_type     <= '0;
            r_code     <= '0;
            r_ident    <= '0;
            r_seq      <= '0;
            r_exp_seq  <= '0;
            r_mismatch <= 1'b0;
            r_pending  <= '0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_csum     <= n_csum;
            r_type     <= n_type;
            r_code     <= n_code;
            r_ident    <= n_ident;
            r_seq      <= n_seq;
            r_exp_seq  <= n_exp_seq;
            r_mismatch <= n_mismatch;
            r_pending  <= n_pending;
        end
    end

endmodule

// File: rtl/icv_outbuf.sv
`timescale 1ns / 1ps
// Result register with a skid stage on the output channel.
module icv_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  icv_pkg::t_result i_result,
    output logic             o_full,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output icv_pkg::t_result o_result
);

    logic             r_out_valid;
    logic             r_skid_valid;
    icv_pkg::t_result r_out;
    icv_pkg::t_result r_skid;
    logic             w_take;

    assign w_take      = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || w_take) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end else if (w_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule

// File: rtl/icmp_echo_reply_validator.sv
`timescale 1ns / 1ps
// Top level of the ICMP echo reply validator: registers, checker and output buffer.
// The block takes one message byte per transfer and can accept a byte in every cycle;
// each byte is folded into the header capture, payload compare and ones-complement sum
// in the same cycle it is accepted; the final byte's status goes to the result register, or to
// the skid stage if the output stalls. The two hold up to two statuses; the input stalls
// while the skid stage is occupied, which only happens after the output side stalled.
module icmp_echo_reply_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_expected_seq,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_reply_code
);

    icv_pkg::t_cfg    r_cfg;
    icv_pkg::t_result w_push_result;
    icv_pkg::t_result w_out_result;
    logic             w_accept;
    logic             w_push;
    logic             w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ipv4_mode       <= 1'b1;
            r_cfg.own_ident       <= '0;
            r_cfg.payload_pattern <= icv_pkg::PATTERN_RESET;
            r_cfg.payload_length  <= icv_pkg::LEN_W'(icv_pkg::MAX_PAYLOAD_BYTES);
        end else if (i_cfg_we) begin
            unique case (icv_pkg::t_reg_index'(i_cfg_index))
                icv_pkg::REG_IPV4_MODE:       r_cfg.ipv4_mode       <= i_cfg_wdata[0];
                icv_pkg::REG_OWN_IDENT:       r_cfg.own_ident       <= i_cfg_wdata[15:0];
                icv_pkg::REG_PAYLOAD_PATTERN: r_cfg.payload_pattern <= i_cfg_wdata;
                icv_pkg::REG_PAYLOAD_LENGTH:
                    r_cfg.payload_length <= i_cfg_wdata[icv_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    icv_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (w_accept),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_expected_seq (i_expected_seq),
        .o_push         (w_push),
        .o_result       (w_push_result)
    );

    icv_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_result    (w_push_result),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_out_result)
    );

    assign o_status     = w_out_result.status;
    assign o_reply_code = w_out_result.reply_code;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_byte) |=> o_out_valid)
        else $error("final byte transfer did not produce a result");

    a_code_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != icv_pkg::ST_OK) |-> (o_reply_code == 8'd0))
        else $error("reply code is nonzero on a failing status");

    a_reset_clears_stall: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_in_stall)
        else $error("input stalled right after reset");

endmodule
